// ===== src/bbdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbdc_pkg;

  localparam int unsigned NUM_STAGES = 6;

  localparam longint LOG2E_Q30 = 64'sd1549082005;
  localparam logic [63:0] LN2_Q31 = 64'd1488522236;
  localparam logic [27:0] EXP_SAT = 28'hFFF_FFFF;

  localparam logic [15:0] INV_WEIGHT_XY_RST = 16'd6554;
  localparam logic [15:0] INV_WEIGHT_WH_RST = 16'd13107;
  localparam logic [12:0] IMAGE_DIM_RST = 13'd4096;

  typedef enum logic [2:0] {
    REG_INV_WEIGHT_X = 3'd0,
    REG_INV_WEIGHT_Y = 3'd1,
    REG_INV_WEIGHT_W = 3'd2,
    REG_INV_WEIGHT_H = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
    logic [15:0] score_in;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x1;
    logic [15:0] out_y1;
    logic [15:0] out_x2;
    logic [15:0] out_y2;
    logic [15:0] score_out;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] inv_weight_x;
    logic [15:0] inv_weight_y;
    logic [15:0] inv_weight_w;
    logic [15:0] inv_weight_h;
    logic [15:0] bound_x;
    logic [15:0] bound_y;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/bbox_delta_decode_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  in_data_i  (bbdc_pkg::in_item_t)
// out       source     out_valid_o / out_stall_i out_data_o (bbdc_pkg::out_item_t)
// cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One box-class pair is accepted every cycle unless a stall has filled every stage; each
// result is shown after it passes the six register stages of the two axis datapaths.
// Reset clears the stage valid bits and loads the register defaults; the exp table
// is a constant, so no sweep follows reset.
// A stall holds only the stages that are blocked; empty stages still fill, so the
// input keeps taking transfers until every stage holds a result.

module bbox_delta_decode_clip #(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire bbdc_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output bbdc_pkg::out_item_t        out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i
);

  localparam int unsigned NS = bbdc_pkg::NUM_STAGES;

  bbdc_pkg::cfg_t cfg;
  logic [NS-1:0]  valid_q, valid_d;
  logic [NS-1:0]  adv;
  logic [16:0]    side_q [NS];
  logic [15:0]    x1, x2, y1, y2;

  bbdc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NS; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= {in_data_i.score_in, in_data_i.last_in};
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  bbdc_axis #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .lo_i    (in_data_i.box_x1),
    .hi_i    (in_data_i.box_x2),
    .dc_i    (in_data_i.delta_x),
    .ds_i    (in_data_i.delta_w),
    .wc_i    (cfg.inv_weight_x),
    .ws_i    (cfg.inv_weight_w),
    .bound_i (cfg.bound_x),
    .lo_o    (x1),
    .hi_o    (x2)
  );

  bbdc_axis #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .lo_i    (in_data_i.box_y1),
    .hi_i    (in_data_i.box_y2),
    .dc_i    (in_data_i.delta_y),
    .ds_i    (in_data_i.delta_h),
    .wc_i    (cfg.inv_weight_y),
    .ws_i    (cfg.inv_weight_h),
    .bound_i (cfg.bound_y),
    .lo_o    (y1),
    .hi_o    (y2)
  );

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NS-1];

  always_comb begin
    out_data_o.out_x1    = x1;
    out_data_o.out_y1    = y1;
    out_data_o.out_x2    = x2;
    out_data_o.out_y2    = y2;
    out_data_o.score_out = side_q[NS-1][16:1];
    out_data_o.last_out  = side_q[NS-1][0];
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a stage is empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted transfer did not enter the first stage");

  a_blocked_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[2] && !adv[2]) |=> valid_q[2])
    else $error("blocked stage lost its item");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !valid_q[NS-2]) |=> !out_valid_o)
    else $error("result repeated after transfer out");
`endif

endmodule

`default_nettype wire

// ===== src/bbdc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbdc_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  output bbdc_pkg::cfg_t     cfg_o
);

  logic [15:0] inv_wx_q, inv_wy_q, inv_ww_q, inv_wh_q;
  logic [12:0] img_w_q, img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_wx_q <= bbdc_pkg::INV_WEIGHT_XY_RST;
      inv_wy_q <= bbdc_pkg::INV_WEIGHT_XY_RST;
      inv_ww_q <= bbdc_pkg::INV_WEIGHT_WH_RST;
      inv_wh_q <= bbdc_pkg::INV_WEIGHT_WH_RST;
      img_w_q  <= bbdc_pkg::IMAGE_DIM_RST;
      img_h_q  <= bbdc_pkg::IMAGE_DIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbdc_pkg::REG_INV_WEIGHT_X: inv_wx_q <= cfg_data_i;
        bbdc_pkg::REG_INV_WEIGHT_Y: inv_wy_q <= cfg_data_i;
        bbdc_pkg::REG_INV_WEIGHT_W: inv_ww_q <= cfg_data_i;
        bbdc_pkg::REG_INV_WEIGHT_H: inv_wh_q <= cfg_data_i;
        bbdc_pkg::REG_IMAGE_WIDTH:  img_w_q  <= cfg_data_i[12:0];
        bbdc_pkg::REG_IMAGE_HEIGHT: img_h_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // The clamp bound is (dim - 1) pixels in Q12.4, zero for a zero dimension and
  // saturated to the largest code.
  function automatic logic [15:0] dim_bound(logic [12:0] dim);
    logic [16:0] b;
    b = {(dim - 13'd1), 4'b0000};
    if (dim == 13'd0) begin
      return 16'd0;
    end else if (b[16]) begin
      return 16'hFFFF;
    end else begin
      return b[15:0];
    end
  endfunction

  always_comb begin
    cfg_o.inv_weight_x = inv_wx_q;
    cfg_o.inv_weight_y = inv_wy_q;
    cfg_o.inv_weight_w = inv_ww_q;
    cfg_o.inv_weight_h = inv_wh_q;
    cfg_o.bound_x      = dim_bound(img_w_q);
    cfg_o.bound_y      = dim_bound(img_h_q);
  end

endmodule

`default_nettype wire

// ===== src/bbdc_exp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbdc_exp #(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  wire logic               clk_i,
  input  wire logic [2:0]         en_i,
  input  wire logic signed [31:0] ds_i,
  output logic [27:0]             e_o
);

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_ENTRIES);

  typedef logic [EXP_TABLE_ENTRIES-1:0][31:0] tab_t;

  // Mantissa table 2^(i/N) in Q1.30 from a truncated Taylor series of exp.
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      x    = (64'(i) * bbdc_pkg::LN2_Q31 + 64'(EXP_TABLE_ENTRIES / 2))
             / 64'(EXP_TABLE_ENTRIES);
      sum  = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int n = 1; n <= 24; n++) begin
        if (term != 64'd0) begin
          term = ((term * x) >> 31) / 64'(n);
          sum  = sum + term;
        end
      end
      tab[i] = 32'((sum + 64'd1) >> 1);
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  logic signed [63:0] prod;
  logic signed [32:0] t_d, t_q;
  logic signed [4:0]  k_d, k_q;
  logic [40:0]        idx_full;
  logic [IDX_W-1:0]   idx;
  logic [31:0]        m_d, m_q;
  logic [6:0]         sh;
  logic [51:0]        scaled;
  logic [27:0]        e_d, e_q;

  always_comb begin
    prod     = 64'(ds_i) * bbdc_pkg::LOG2E_Q30;
    t_d      = 33'(prod >>> 30);
    k_d      = t_q[32:28];
    idx_full = 41'(t_q[27:0]) * 41'(EXP_TABLE_ENTRIES);
    idx      = idx_full[28 +: IDX_W];
    m_d      = EXP_TAB[idx];
    sh       = 7'd34 - 7'(k_q);
    scaled   = {m_q, 20'b0} >> sh;
    e_d      = (scaled > 52'(bbdc_pkg::EXP_SAT)) ? bbdc_pkg::EXP_SAT : scaled[27:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t_q <= t_d;
    end
    if (en_i[1]) begin
      k_q <= k_d;
      m_q <= m_d;
    end
    if (en_i[2]) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

`default_nettype wire

// ===== src/bbdc_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbdc_axis #(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  wire logic                              clk_i,
  input  wire logic [bbdc_pkg::NUM_STAGES-1:0]   en_i,
  input  wire logic [15:0]                       lo_i,
  input  wire logic [15:0]                       hi_i,
  input  wire logic signed [15:0]                dc_i,
  input  wire logic signed [15:0]                ds_i,
  input  wire logic [15:0]                       wc_i,
  input  wire logic [15:0]                       ws_i,
  input  wire logic [15:0]                       bound_i,
  output logic [15:0]                            lo_o,
  output logic [15:0]                            hi_o
);

  logic signed [17:0] w_d, w1_q, w2_q, w3_q, w4_q;
  logic [15:0]        lo1_q;
  logic signed [31:0] dc_d, dc1_q, ds_d, ds1_q;
  logic signed [46:0] ctr_d, ctr2_q;
  logic signed [49:0] wdc_d, wdc2_q;
  logic signed [50:0] pc_d, pc3_q, pc4_q, pc5_q;
  logic [27:0]        e4;
  logic signed [45:0] half_d, half5_q;
  logic signed [57:0] half_s, v_lo, v_hi;
  logic [15:0]        lo_d, hi_d, lo6_q, hi6_q;

  function automatic logic [15:0] clamp_coord(logic signed [29:0] r, logic [15:0] bound);
    if (r < 30'sd0) begin
      return 16'd0;
    end else if (r > $signed({14'b0, bound})) begin
      return bound;
    end else begin
      return r[15:0];
    end
  endfunction

  bbdc_exp #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk_i (clk_i),
    .en_i  (en_i[3:1]),
    .ds_i  (ds1_q),
    .e_o   (e4)
  );

  always_comb begin
    w_d    = $signed({2'b00, hi_i}) - $signed({2'b00, lo_i}) + 18'sd16;
    dc_d   = 32'(dc_i * $signed({1'b0, wc_i}));
    ds_d   = 32'(ds_i * $signed({1'b0, ws_i}));
    ctr_d  = $signed({3'b000, lo1_q, 28'b0}) + (47'(w1_q) <<< 27);
    wdc_d  = 50'(w1_q * dc1_q);
    pc_d   = 51'(ctr2_q) + 51'(wdc2_q);
    half_d = 46'(w4_q * $signed({1'b0, e4}));
    half_s = 58'(half5_q) <<< 11;
    v_lo   = 58'(pc5_q) - half_s + 58'sd134217728;
    v_hi   = 58'(pc5_q) + half_s + 58'sd134217728;
    lo_d   = clamp_coord(v_lo[57:28], bound_i);
    hi_d   = clamp_coord(v_hi[57:28], bound_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      w1_q  <= w_d;
      lo1_q <= lo_i;
      dc1_q <= dc_d;
      ds1_q <= ds_d;
    end
    if (en_i[1]) begin
      w2_q   <= w1_q;
      ctr2_q <= ctr_d;
      wdc2_q <= wdc_d;
    end
    if (en_i[2]) begin
      w3_q  <= w2_q;
      pc3_q <= pc_d;
    end
    if (en_i[3]) begin
      w4_q  <= w3_q;
      pc4_q <= pc3_q;
    end
    if (en_i[4]) begin
      half5_q <= half_d;
      pc5_q   <= pc4_q;
    end
    if (en_i[5]) begin
      lo6_q <= lo_d;
      hi6_q <= hi_d;
    end
  end

  assign lo_o = lo6_q;
  assign hi_o = hi6_q;

endmodule

`default_nettype wire

// ===== dv/bbox_delta_decode_clip_test.sv =====
`timescale 1ns / 1ps

module bbox_delta_decode_clip_test;
  import bbdc_pkg::*;

  localparam int EXP_ENTRIES = 256;
  localparam longint LOG2E_Q30 = 64'sd1549082005;
  localparam longint unsigned LN2_Q31 = 64'd1488522236;
  localparam longint unsigned EXP_CAP = 64'd268435455;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int STUCK_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  bbox_delta_decode_clip #(
    .EXP_TABLE_ENTRIES(EXP_ENTRIES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Register copies seen by the predictor; they change only while the block is idle.
  logic [15:0] wt_x = INV_WEIGHT_XY_RST;
  logic [15:0] wt_y = INV_WEIGHT_XY_RST;
  logic [15:0] wt_w = INV_WEIGHT_WH_RST;
  logic [15:0] wt_h = INV_WEIGHT_WH_RST;
  logic [12:0] img_w = IMAGE_DIM_RST;
  logic [12:0] img_h = IMAGE_DIM_RST;

  longint unsigned exp_lut[EXP_ENTRIES];

  in_item_t pending_boxes[$];
  out_item_t decoded_boxes[$];

  logic in_fire = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int seg_left = 0;
  int stall_pct = 0;
  int stuck_cycles = 0;
  int errors = 0;

  function automatic void build_exp_lut();
    longint unsigned x;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned n;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      x = (longint'(i) * LN2_Q31 + EXP_ENTRIES / 2) / EXP_ENTRIES;
      sum = 64'd1 << 31;
      term = 64'd1 << 31;
      for (n = 1; n <= 24 && term != 0; n++) begin
        term = ((term * x) >> 31) / n;
        sum += term;
      end
      exp_lut[i] = (sum + 1) >> 1;
    end
  endfunction

  // exp of a Q.28 argument, as unsigned Q12.16 with saturation.
  function automatic longint unsigned exp_q16(longint d);
    longint t;
    longint k;
    longint f;
    longint unsigned idx;
    longint unsigned m;
    longint unsigned e;
    t = (d * LOG2E_Q30) >>> 30;
    k = t >>> 28;
    f = t - (k <<< 28);
    idx = (f * EXP_ENTRIES) >> 28;
    if (idx >= EXP_ENTRIES) begin
      idx = EXP_ENTRIES - 1;
    end
    m = exp_lut[idx];
    if (k >= 0) begin
      if (k > 20) begin
        return EXP_CAP;
      end
      e = (m << k) >> 14;
    end else if (14 - k >= 63) begin
      e = 0;
    end else begin
      e = m >> (14 - k);
    end
    return (e > EXP_CAP) ? EXP_CAP : e;
  endfunction

  function automatic logic [15:0] clip_q4(longint v, logic [12:0] dim);
    longint r;
    longint bound;
    r = (v + (64'sd1 <<< 27)) >>> 28;
    bound = (dim == 0) ? 0 : (longint'(dim) - 1) * 16;
    if (bound > 65535) begin
      bound = 65535;
    end
    if (r < 0) begin
      return 16'd0;
    end
    if (r > bound) begin
      return bound[15:0];
    end
    return r[15:0];
  endfunction

  function automatic void decode_axis(input logic [15:0] lo, input logic [15:0] hi,
                                      input logic signed [15:0] dc,
                                      input logic signed [15:0] ds,
                                      input logic [15:0] wc, input logic [15:0] ws,
                                      input logic [12:0] dim,
                                      output logic [15:0] o_lo, output logic [15:0] o_hi);
    longint w;
    longint ctr;
    longint pc;
    longint half;
    w = longint'(hi) - longint'(lo) + 16;
    ctr = (longint'(lo) <<< 28) + w * (64'sd1 <<< 27);
    pc = ctr + w * (longint'(dc) * longint'(wc));
    half = w * longint'(exp_q16(longint'(ds) * longint'(ws))) * 2048;
    o_lo = clip_q4(pc - half, dim);
    o_hi = clip_q4(pc + half, dim);
  endfunction

  function automatic out_item_t decode_box(in_item_t it);
    out_item_t r;
    logic [15:0] a;
    logic [15:0] b;
    decode_axis(it.box_x1, it.box_x2, it.delta_x, it.delta_w, wt_x, wt_w, img_w, a, b);
    r.out_x1 = a;
    r.out_x2 = b;
    decode_axis(it.box_y1, it.box_y2, it.delta_y, it.delta_h, wt_y, wt_h, img_h, a, b);
    r.out_y1 = a;
    r.out_y2 = b;
    r.score_out = it.score_in;
    r.last_out = it.last_in;
    return r;
  endfunction

  function automatic in_item_t mk_box(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                                      logic [15:0] y2, logic [15:0] dx, logic [15:0] dy,
                                      logic [15:0] dw, logic [15:0] dh, logic [15:0] sc,
                                      logic lst);
    in_item_t it;
    it.box_x1 = x1;
    it.box_y1 = y1;
    it.box_x2 = x2;
    it.box_y2 = y2;
    it.delta_x = dx;
    it.delta_y = dy;
    it.delta_w = dw;
    it.delta_h = dh;
    it.score_in = sc;
    it.last_in = lst;
    return it;
  endfunction

  function automatic logic [15:0] rand_delta();
    int r;
    int v;
    case ($urandom_range(0, 3))
      0: r = 1024;
      1: r = 8192;
      2: r = 20000;
      default: r = 32767;
    endcase
    v = int'($urandom_range(0, 2 * r)) - r;
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_corner(output logic [15:0] hi);
    int lo;
    int span;
    lo = $urandom_range(0, 64000);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30000) : $urandom_range(0, 4000);
    hi = (lo + span > 65535) ? 16'hFFFF : 16'(lo + span);
    return 16'(lo);
  endfunction

  // Mostly plausible proposals with deltas of varied magnitude, the rest raw noise.
  function automatic in_item_t rand_box();
    in_item_t it;
    logic [15:0] hi;
    if ($urandom_range(0, 4) == 0) begin
      it = mk_box(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 1'($urandom_range(0, 1)));
    end else begin
      it.box_x1 = rand_corner(hi);
      it.box_x2 = hi;
      it.box_y1 = rand_corner(hi);
      it.box_y2 = hi;
      it.delta_x = rand_delta();
      it.delta_y = rand_delta();
      it.delta_w = rand_delta();
      it.delta_h = rand_delta();
      it.score_in = 16'($urandom());
      it.last_in = ($urandom_range(0, 7) == 0);
    end
    return it;
  endfunction

  task automatic add_box(in_item_t it);
    pending_boxes.insert(pending_boxes.size(), it);
  endtask

  task automatic queue_random(int n);
    repeat (n) add_box(rand_box());
  endtask

  task automatic wait_drained();
    while (pending_boxes.size() != 0 || decoded_boxes.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_INV_WEIGHT_X: wt_x = val;
      REG_INV_WEIGHT_Y: wt_y = val;
      REG_INV_WEIGHT_W: wt_w = val;
      REG_INV_WEIGHT_H: wt_h = val;
      REG_IMAGE_WIDTH: img_w = val[12:0];
      REG_IMAGE_HEIGHT: img_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_weights(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic [15:0] h);
    write_reg(REG_INV_WEIGHT_X, x);
    write_reg(REG_INV_WEIGHT_Y, y);
    write_reg(REG_INV_WEIGHT_W, w);
    write_reg(REG_INV_WEIGHT_H, h);
  endtask

  task automatic set_dims(logic [15:0] w, logic [15:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_box(out_item_t want, out_item_t got);
    check_field("out_x1", want.out_x1, got.out_x1);
    check_field("out_y1", want.out_y1, got.out_y1);
    check_field("out_x2", want.out_x2, got.out_x2);
    check_field("out_y2", want.out_y2, got.out_y2);
    check_field("score_out", want.score_out, got.score_out);
    check_field("last_out", 16'(want.last_out), 16'(got.last_out));
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_boxes.size() > 0) begin
        in_data_i <= pending_boxes.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: segments of differing stall density, plus requested long holds.
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(10, 200);
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 20;
          3: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        decoded_boxes.insert(decoded_boxes.size(), decode_box(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (decoded_boxes.size() == 0) begin
          $error("Result transfer with no expected box waiting.");
          errors++;
        end else begin
          compare_box(decoded_boxes.pop_front(), out_data_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (!in_valid_i && pending_boxes.size() == 0 && decoded_boxes.size() == 0)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[bbox_delta_decode_clip] ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    build_exp_lut();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    add_box(mk_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    add_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1));
    add_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    add_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                   16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 1'b1));
    add_box(mk_box(16'hF000, 16'hE000, 16'h1000, 16'h0800, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b0));
    add_box(mk_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h4000,
                   16'hC000, 16'h2000, 16'hE000, 16'h7FFF, 1'b0));
    add_box(mk_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
    add_box(mk_box(16'h1000, 16'h2000, 16'h1800, 16'h2C00, 16'h0400,
                   16'hFC00, 16'h0200, 16'hFE00, 16'h4000, 1'b0));
    add_box(mk_box(16'h0010, 16'h0010, 16'h0100, 16'h0100, 16'h8000,
                   16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    add_box(mk_box(16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                   16'h7FFF, 16'h0000, 16'h0000, 16'hA5A5, 1'b1));
    add_box(mk_box(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555,
                   16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    add_box(mk_box(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA,
                   16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1));
    queue_random(240);
    wait_drained();

    set_weights(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    set_dims(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
    queue_random(250);
    // Hold the result side while the sender keeps offering, so the input backs up.
    hold_reqs++;
    wait_drained();

    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_dims(16'd4096, 16'd4096);
    add_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1));
    add_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0));
    queue_random(150);
    wait_drained();

    set_weights(16'd1, 16'd1, 16'd1, 16'd1);
    set_dims(16'd1, 16'd1);
    queue_random(150);
    wait_drained();

    // A zero weight removes the shift and the scaling; a zero dimension pins every corner.
    set_weights(16'd0, 16'd0, 16'd0, 16'd0);
    set_dims(16'd0, 16'd0);
    write_reg(REG_SPARE_6, 16'($urandom()));
    write_reg(REG_SPARE_7, 16'($urandom()));
    add_box(mk_box(16'h1000, 16'h1000, 16'h2000, 16'h2000, 16'h7FFF,
                   16'h8000, 16'h7FFF, 16'h8000, 16'h0F0F, 1'b1));
    queue_random(100);
    wait_drained();

    // Dimensions at and above the image limit, including data bits beyond the register width.
    set_weights(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    set_dims(16'hFFFF, 16'h3000);
    queue_random(100);
    wait_drained();
    set_dims(16'd4097, 16'd8191);
    queue_random(50);
    wait_drained();

    set_weights(INV_WEIGHT_XY_RST, INV_WEIGHT_XY_RST, INV_WEIGHT_WH_RST, INV_WEIGHT_WH_RST);
    set_dims(16'($urandom_range(16, 2048)), 16'($urandom_range(16, 2048)));
    queue_random(200);
    wait_drained();
    repeat (4 * NUM_STAGES) @(posedge clk_i);

    if (errors == 0 && decoded_boxes.size() == 0) begin
      $display("[bbox_delta_decode_clip] OK");
    end else begin
      $display("[bbox_delta_decode_clip] ERROR");
    end
    $finish;
  end

endmodule
